// ===== design/i2cmbe_pkg.sv =====
`default_nettype none

package i2cmbe_pkg;

    // command codes carried in the action field
    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // configuration register indexes
    localparam logic [7:0] REG_TICKS_PER_DELAY = 8'd0;
    localparam logic [7:0] REG_ACK_POLL_LIMIT  = 8'd1;

    // configuration reset values
    localparam logic [7:0] TICKS_PER_DELAY_RST = 8'd1;
    localparam logic [7:0] ACK_POLL_LIMIT_RST  = 8'd250;

    // number of data bits in one byte transfer
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       no_ack;
    } out_item_t;

    typedef struct packed {
        logic [7:0] ticks_per_delay;
        logic [7:0] ack_poll_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== design/i2c_master_byte_engine_core.sv =====
// I2C master byte engine: every request is one bus tick carrying the sampled SDA level,
// and while the engine is idle it may also launch a start, stop, write or read. Each
// request yields exactly one response with the SCL/SDA levels and drive enable to put
// on the pins, busy and done flags, the last received byte and the no-acknowledge flag.
// A request is taken every clock while in_ready is high; it is held in the input register,
// is resolved against the sequencer state in one pass, and its response is loaded into the
// result register once it is free or being emptied, and from there it is offered on
// out_valid. in_ready drops only when both the input register and an untaken result are
// full. Registers (ticks_per_delay, ack_poll_limit) are written through the cfg port,
// which is always ready, and should be changed only while the engine is idle and drained.
`default_nettype none

module i2c_master_byte_engine_core
    import i2cmbe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    in_item_t  in_q_reg;
    logic      in_v_reg;
    out_item_t out_q_reg;
    logic      out_v_reg;
    cfg_t      cfg_reg;
    out_item_t step_res;
    logic      fire;

    // a request moves on when the result register is free or being emptied
    assign fire      = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready  = !in_v_reg || fire;
    assign cfg_ready = 1'b1;
    assign out_valid = out_v_reg;
    assign out_data  = out_q_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_delay <= TICKS_PER_DELAY_RST;
            cfg_reg.ack_poll_limit  <= ACK_POLL_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TICKS_PER_DELAY: cfg_reg.ticks_per_delay <= cfg_data;
                REG_ACK_POLL_LIMIT:  cfg_reg.ack_poll_limit  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_q_reg <= in_data;
        end
    end

    i2cmbe_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_q_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_q_reg <= step_res;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cmbe_step.sv =====
`default_nettype none

module i2cmbe_step
    import i2cmbe_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire in_item_t  item,
    input  wire cfg_t      cfg,
    output out_item_t      res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_WR_HI   = 4'd5;
    localparam logic [3:0] PH_WR_LO   = 4'd6;
    localparam logic [3:0] PH_WA_REL  = 4'd7;
    localparam logic [3:0] PH_WA_HI   = 4'd8;
    localparam logic [3:0] PH_WA_POLL = 4'd9;
    localparam logic [3:0] PH_RD_LO   = 4'd10;
    localparam logic [3:0] PH_RD_HI   = 4'd11;
    localparam logic [3:0] PH_RA_A    = 4'd12;
    localparam logic [3:0] PH_RA_B    = 4'd13;

    logic [3:0] phase_reg, phase_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] delay_reg, delay_next;
    logic [7:0] poll_reg, poll_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       drive_reg, drive_next;
    logic       nack_reg, nack_next;
    logic [7:0] rx_reg, rx_next;
    logic       done;
    logic       do_poll;
    logic [7:0] slot;

    // next state for one tick
    always_comb
    begin
        phase_next      = phase_reg;
        cmd_next        = cmd_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        delay_next      = delay_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        drive_next      = drive_reg;
        nack_next       = nack_reg;
        rx_next         = rx_reg;
        done            = 1'b0;
        do_poll         = 1'b0;
        slot            = (cfg.ticks_per_delay == 8'd0) ? 8'd1 : cfg.ticks_per_delay;

        if (phase_reg == PH_IDLE)
        begin
            // command launch
            case (item.action)
                CMD_START:
                begin
                    cmd_next   = item.action;
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = PH_ST_A;
                    delay_next = slot;
                end
                CMD_STOP:
                begin
                    cmd_next   = item.action;
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = PH_SP_A;
                    delay_next = slot;
                end
                CMD_WRITE:
                begin
                    cmd_next   = item.action;
                    bit_next   = 4'd0;
                    poll_next  = 8'd0;
                    drive_next = 1'b1;
                    sda_next   = item.tx_byte[7];
                    shift_next = {item.tx_byte[6:0], 1'b0};
                    scl_next   = 1'b1;
                    phase_next = PH_WR_HI;
                    delay_next = slot;
                end
                CMD_READ:
                begin
                    cmd_next        = item.action;
                    bit_next        = 4'd0;
                    shift_next      = 8'd0;
                    ack_choice_next = item.send_ack;
                    drive_next      = 1'b0;
                    scl_next        = 1'b0;
                    phase_next      = PH_RD_LO;
                    delay_next      = slot;
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == PH_WA_POLL)
        begin
            do_poll = 1'b1;
        end
        else if (delay_reg > 8'd1)
        begin
            delay_next = delay_reg - 8'd1;
        end
        else
        begin
            // slot expired, move to next segment
            case (phase_reg)
                PH_ST_A:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                    delay_next = slot;
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    delay_next = 8'd0;
                    done       = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_B;
                    delay_next = slot;
                end
                PH_SP_B:
                begin
                    if (cmd_reg == CMD_WRITE)
                    begin
                        nack_next = 1'b1;
                    end
                    phase_next = PH_IDLE;
                    delay_next = 8'd0;
                    done       = 1'b1;
                end
                PH_WR_HI:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_WR_LO;
                    delay_next = slot;
                end
                PH_WR_LO:
                begin
                    bit_next = bit_reg + 4'd1;
                    if (bit_next < BITS_PER_BYTE)
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        scl_next   = 1'b1;
                        phase_next = PH_WR_HI;
                    end
                    else
                    begin
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_WA_REL;
                    end
                    delay_next = slot;
                end
                PH_WA_REL:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_HI;
                    delay_next = slot;
                end
                PH_WA_HI:
                begin
                    do_poll = 1'b1;
                end
                PH_RD_LO:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_reg[6:0], item.sda_in};
                    phase_next = PH_RD_HI;
                    delay_next = slot;
                end
                PH_RD_HI:
                begin
                    bit_next = bit_reg + 4'd1;
                    scl_next = 1'b0;
                    if (bit_next < BITS_PER_BYTE)
                    begin
                        phase_next = PH_RD_LO;
                    end
                    else
                    begin
                        drive_next = 1'b1;
                        sda_next   = ~ack_choice_reg;
                        phase_next = PH_RA_A;
                    end
                    delay_next = slot;
                end
                PH_RA_A:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_RA_B;
                    delay_next = slot;
                end
                PH_RA_B:
                begin
                    scl_next   = 1'b0;
                    rx_next    = shift_reg;
                    phase_next = PH_IDLE;
                    delay_next = 8'd0;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    delay_next = 8'd0;
                    done       = 1'b1;
                end
            endcase
        end

        // acknowledge poll: ack seen, give up with a stop, or keep polling
        if (do_poll)
        begin
            if (!item.sda_in)
            begin
                scl_next   = 1'b0;
                nack_next  = 1'b0;
                phase_next = PH_IDLE;
                delay_next = 8'd0;
                done       = 1'b1;
            end
            else if (poll_reg >= cfg.ack_poll_limit)
            begin
                drive_next = 1'b1;
                scl_next   = 1'b0;
                sda_next   = 1'b0;
                phase_next = PH_SP_A;
                delay_next = slot;
            end
            else
            begin
                poll_next  = poll_reg + 8'd1;
                phase_next = PH_WA_POLL;
            end
        end
    end

    // result seen at the end of this tick
    always_comb
    begin
        res.scl_level = scl_next;
        res.sda_level = sda_next;
        res.sda_drive = drive_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.no_ack    = nack_next;
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            cmd_reg        <= CMD_TICK;
            bit_reg        <= 4'd0;
            shift_reg      <= 8'd0;
            delay_reg      <= 8'd0;
            poll_reg       <= 8'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            drive_reg      <= 1'b1;
            nack_reg       <= 1'b0;
            rx_reg         <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            cmd_reg        <= cmd_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            delay_reg      <= delay_next;
            poll_reg       <= poll_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            drive_reg      <= drive_next;
            nack_reg       <= nack_next;
            rx_reg         <= rx_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/i2cmbe_checker.sv =====
`default_nettype none

module i2cmbe_checker
    import i2cmbe_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // stalled response stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    // stalled response payload unchanged
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("response changed while stalled");

    // a completing command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.done_res |-> !out_data.busy_res)
        else $error("done with engine still busy");

    // idle with released sda only after an acknowledged write, scl low
    a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.busy_res && !out_data.sda_drive |-> !out_data.scl_level)
        else $error("idle with released sda and scl high");

endmodule

bind i2c_master_byte_engine_core i2cmbe_checker u_i2cmbe_checker (.*);

`default_nettype wire
